@@ sv/cce_pkg.sv @@
// Package for the cubical coface enumerator: request, result and command types,
// the coface offset table and group decoding. Depends on nothing else.
`timescale 1ns / 1ps

package cce_pkg;

  localparam int IDX_BITS = 29;

  // Configuration register index; register i sits at byte address 4*i.
  localparam logic REG_THRESHOLD = 1'b0;

  // Group numbering: 0 vertex, 1..3 edge types, 4..6 square types.
  localparam logic [2:0] GRP_VERTEX = 3'd0;
  localparam logic [2:0] GRP_EDGE   = 3'd1;
  localparam logic [2:0] GRP_SQUARE = 3'd4;
  localparam logic [2:0] GRP_NONE   = 3'd7;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [4:0]         cube_x;
    logic [4:0]         cube_y;
    logic [4:0]         cube_z;
    logic [1:0]         cube_dim;
    logic [1:0]         cube_type;
    logic signed [31:0] voxel_value;
    logic signed [31:0] birth_time;
  } cce_req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] coface_index;
    logic signed [31:0]  coface_birth;
    logic [1:0]          coface_dim;
    logic                found;
    logic                last;
  } cce_res_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } offs_t;

  typedef struct packed {
    logic [1:0]        ctype;
    logic signed [1:0] ox;
    logic signed [1:0] oy;
    logic signed [1:0] oz;
    logic [2:0]        nvox;
    offs_t [3:0]       vox;
  } spec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       wr;
    logic       issue;
    logic       flush;
    logic [2:0] group;
    logic [2:0] idx;
    logic [1:0] k;
    logic       first;
    logic       lastv;
  } cce_cmd_t;

  function automatic offs_t o3(input int x, input int y, input int z);
    offs_t o;
    o.dx = 2'(x);
    o.dy = 2'(y);
    o.dz = 2'(z);
    return o;
  endfunction

  function automatic spec_t mk(input int ct, input int ox, input int oy, input int oz,
                               input int n, input offs_t a, input offs_t b,
                               input offs_t c, input offs_t d);
    spec_t s;
    s.ctype  = 2'(ct);
    s.ox     = 2'(ox);
    s.oy     = 2'(oy);
    s.oz     = 2'(oz);
    s.nvox   = 3'(n);
    s.vox[0] = a;
    s.vox[1] = b;
    s.vox[2] = c;
    s.vox[3] = d;
    return s;
  endfunction

  function automatic logic [2:0] cce_group(input logic [1:0] dim, input logic [1:0] ctype);
    logic [2:0] g;
    g = GRP_NONE;
    if (dim == 2'd0) begin
      g = GRP_VERTEX;
    end else if (dim == 2'd1 && ctype != 2'd3) begin
      g = GRP_EDGE + {1'b0, ctype};
    end else if (dim == 2'd2 && ctype != 2'd3) begin
      g = GRP_SQUARE + {1'b0, ctype};
    end
    return g;
  endfunction

  function automatic logic [2:0] group_count(input logic [2:0] group);
    logic [2:0] n;
    case (group)
      3'd0:                   n = 3'd6;
      3'd1, 3'd2, 3'd3:       n = 3'd4;
      3'd4, 3'd5, 3'd6:       n = 3'd2;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic spec_t spec_lookup(input logic [2:0] group, input logic [2:0] i);
    spec_t s;
    offs_t z;
    z = o3(0, 0, 0);
    s = mk(0, 0, 0, 0, 0, z, z, z, z);
    case (group)
      3'd0: begin
        case (i)
          3'd0: s = mk(2, 0, 0,  0, 1, o3( 0,  0,  1), z, z, z);
          3'd1: s = mk(2, 0, 0, -1, 1, o3( 0,  0, -1), z, z, z);
          3'd2: s = mk(1, 0, 0,  0, 1, o3( 0,  1,  0), z, z, z);
          3'd3: s = mk(1, 0, -1, 0, 1, o3( 0, -1,  0), z, z, z);
          3'd4: s = mk(0, 0, 0,  0, 1, o3( 1,  0,  0), z, z, z);
          3'd5: s = mk(0, -1, 0, 0, 1, o3(-1,  0,  0), z, z, z);
          default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
        endcase
      end
      3'd1: begin
        case (i)
          3'd0: s = mk(1, 0, 0,  0, 2, o3(0,  0,  1), o3(1,  0,  1), z, z);
          3'd1: s = mk(1, 0, 0, -1, 2, o3(0,  0, -1), o3(1,  0, -1), z, z);
          3'd2: s = mk(0, 0, 0,  0, 2, o3(0,  1,  0), o3(1,  1,  0), z, z);
          3'd3: s = mk(0, 0, -1, 0, 2, o3(0, -1,  0), o3(1, -1,  0), z, z);
          default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
        endcase
      end
      3'd2: begin
        case (i)
          3'd0: s = mk(2, 0, 0,  0, 2, o3( 0, 0,  1), o3( 0, 1,  1), z, z);
          3'd1: s = mk(2, 0, 0, -1, 2, o3( 0, 0, -1), o3( 0, 1, -1), z, z);
          3'd2: s = mk(0, 0, 0,  0, 2, o3( 1, 0,  0), o3( 1, 1,  0), z, z);
          3'd3: s = mk(0, -1, 0, 0, 2, o3(-1, 0,  0), o3(-1, 1,  0), z, z);
          default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
        endcase
      end
      3'd3: begin
        case (i)
          3'd0: s = mk(2, 0, 0,  0, 2, o3( 0,  1, 0), o3( 0,  1, 1), z, z);
          3'd1: s = mk(2, 0, -1, 0, 2, o3( 0, -1, 0), o3( 0, -1, 1), z, z);
          3'd2: s = mk(1, 0, 0,  0, 2, o3( 1,  0, 0), o3( 1,  0, 1), z, z);
          3'd3: s = mk(1, -1, 0, 0, 2, o3(-1,  0, 0), o3(-1,  0, 1), z, z);
          default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
        endcase
      end
      3'd4: begin
        case (i)
          3'd0: s = mk(0, 0, 0, 0, 4, o3(0, 0, 1), o3(1, 0, 1), o3(0, 1, 1), o3(1, 1, 1));
          3'd1: s = mk(0, 0, 0, -1, 4, o3(0, 0, -1), o3(1, 0, -1), o3(0, 1, -1),
                       o3(1, 1, -1));
          default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
        endcase
      end
      3'd5: begin
        case (i)
          3'd0: s = mk(0, 0, 0, 0, 4, o3(0, 1, 0), o3(1, 1, 0), o3(0, 1, 1), o3(1, 1, 1));
          3'd1: s = mk(0, 0, -1, 0, 4, o3(0, -1, 0), o3(1, -1, 0), o3(0, -1, 1),
                       o3(1, -1, 1));
          default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
        endcase
      end
      3'd6: begin
        case (i)
          3'd0: s = mk(0, 0, 0, 0, 4, o3(1, 0, 0), o3(1, 1, 0), o3(1, 0, 1), o3(1, 1, 1));
          3'd1: s = mk(0, -1, 0, 0, 4, o3(-1, 0, 0), o3(-1, 1, 0), o3(-1, 0, 1),
                       o3(-1, 1, 1));
          default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
        endcase
      end
      default: s = mk(0, 0, 0, 0, 0, z, z, z, z);
    endcase
    return s;
  endfunction

endpackage

@@ sv/cubical_coface_enumerator.sv @@
// Top level of the cubical coface enumerator: configuration register port and
// the controller and datapath. Depends on cce_pkg, cce_ctrl and cce_datapath.
//
//   channel   handshake              payload
//   request   start / busy           req (cce_req_t)
//   result    result_valid strobe    result (cce_res_t)
//   config    psel/penable/pwrite    paddr, pwdata, prdata
//
// A voxel write leaves busy low. A query holds busy while it reads the voxels
// of each coface in turn, then flushes; an invalid cube goes straight to flush.
// The single-port voxel memory allows one read a cycle. The final result of a
// query follows the flush through s1_flush and the result register after busy
// falls; each kept coface is held until the next one. Reset clears control
// state, sets the threshold to maximum; voxel memory is undefined until written.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module cubical_coface_enumerator
  import cce_pkg::*;
#(
  parameter int COORD_BITS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cce_req_t    req,
  output logic        busy,
  output logic        result_valid,
  output cce_res_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [31:0] skip_threshold;
  cce_cmd_t           cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? skip_threshold : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_threshold <= 32'sh7FFF_FFFF;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      skip_threshold <= pwdata;
    end
  end

  cce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .cmd   (cmd)
  );

  cce_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req          (req),
    .thr          (skip_threshold),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ sv/cce_ctrl.sv @@
// Controller of the coface enumerator: walks cofaces and their voxels one step
// a cycle and drives the datapath by commands. Depends on cce_pkg.
`timescale 1ns / 1ps

module cce_ctrl
  import cce_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cce_req_t req,
  output logic     busy,
  output cce_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] group, group_next;
  logic [2:0] idx, idx_next;
  logic [1:0] k, k_next;

  logic       accept;
  logic [2:0] req_group;
  spec_t      sp;
  logic       lastv;

  assign accept    = start && !busy;
  assign req_group = cce_group(req.cube_dim, req.cube_type);
  assign sp        = spec_lookup(group, idx);
  assign lastv     = ({1'b0, k} == sp.nvox - 3'd1);
  assign busy      = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    group_next = group;
    idx_next   = idx;
    k_next     = k;
    cmd        = '0;
    cmd.group  = group;
    cmd.idx    = idx;
    cmd.k      = k;
    cmd.first  = (k == 2'd0);
    cmd.lastv  = lastv;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_QUERY) begin
            cmd.load   = 1'b1;
            group_next = req_group;
            idx_next   = 3'd0;
            k_next     = 2'd0;
            state_next = (req_group == GRP_NONE) ? ST_FLUSH : ST_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (lastv) begin
          k_next = 2'd0;
          if (idx == group_count(group) - 3'd1) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + 3'd1;
          end
        end else begin
          k_next = k + 2'd1;
        end
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      group <= GRP_NONE;
      idx   <= 3'd0;
      k     <= 2'd0;
    end else begin
      state <= state_next;
      group <= group_next;
      idx   <= idx_next;
      k     <= k_next;
    end
  end

  a_flush_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |=> state == ST_IDLE)
    else $error("controller stayed in flush");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> ({1'b0, k} < sp.nvox && idx < group_count(group)))
    else $error("voxel step beyond the coface table");

  a_bad_query: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == KIND_QUERY && req_group == GRP_NONE) |=> state == ST_FLUSH)
    else $error("invalid query did not go straight to flush");

endmodule

@@ sv/cce_datapath.sv @@
// Datapath of the coface enumerator: voxel memory, neighbour address and bounds
// logic, running maximum, one-deep result hold and the result register. Depends on cce_pkg.
`timescale 1ns / 1ps

module cce_datapath
  import cce_pkg::*;
#(
  parameter int COORD_BITS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  cce_cmd_t           cmd,
  input  cce_req_t           req,
  input  logic signed [31:0] thr,
  output logic               result_valid,
  output cce_res_t           result
);

  localparam int CB = COORD_BITS;
  localparam int AW = 3 * COORD_BITS;
  localparam int GRID_WORDS = 1 << AW;

  logic signed [31:0] mem [GRID_WORDS];
  logic signed [31:0] rd_data;

  logic [CB-1:0]      cx, cy, cz;
  logic signed [31:0] bt;
  logic [1:0]         dim_q;

  logic [CB-1:0]      wx, wy, wz;
  spec_t              sp;
  offs_t              off;
  logic [CB:0]        nx, ny, nz;
  logic               oob, re;
  logic [AW-1:0]      raddr;
  logic [IDX_BITS-1:0] index0;

  logic                s1_issue, s1_flush, s1_oob, s1_first, s1_lastv;
  logic [IDX_BITS-1:0] s1_index;

  logic signed [31:0] acc, v, base, m;
  logic               pend_valid;
  logic [IDX_BITS-1:0] pend_index;
  logic signed [31:0] pend_birth;

  // Coordinates use only the low COORD_BITS bits of the request fields.
  assign wx = CB'({4'b0, req.cube_x});
  assign wy = CB'({4'b0, req.cube_y});
  assign wz = CB'({4'b0, req.cube_z});

  assign sp  = spec_lookup(cmd.group, cmd.idx);
  assign off = sp.vox[cmd.k];
  // A neighbour at -1 or at the grid side sets the top bit of the widened sum.
  assign nx  = {1'b0, cx} + {{(CB - 1){off.dx[1]}}, off.dx};
  assign ny  = {1'b0, cy} + {{(CB - 1){off.dy[1]}}, off.dy};
  assign nz  = {1'b0, cz} + {{(CB - 1){off.dz[1]}}, off.dz};
  assign oob = nx[CB] | ny[CB] | nz[CB];
  assign re  = cmd.issue && !oob;
  assign raddr = {nx[CB-1:0], ny[CB-1:0], nz[CB-1:0]};

  assign index0 = {sp.ctype,
                   9'(cz) + {{7{sp.oz[1]}}, sp.oz},
                   9'(cy) + {{7{sp.oy[1]}}, sp.oy},
                   9'(cx) + {{7{sp.ox[1]}}, sp.ox}};

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[{wx, wy, wz}] <= req.voxel_value;
    end else if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= wx;
      cy    <= wy;
      cz    <= wz;
      bt    <= req.birth_time;
      dim_q <= req.cube_dim;
    end
    s1_index <= index0;
  end

  assign v    = s1_oob ? thr : rd_data;
  assign base = s1_first ? bt : acc;
  assign m    = (v > base) ? v : base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_issue     <= 1'b0;
      s1_flush     <= 1'b0;
      s1_oob       <= 1'b0;
      s1_first     <= 1'b0;
      s1_lastv     <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_issue     <= cmd.issue;
      s1_flush     <= cmd.flush;
      s1_oob       <= oob;
      s1_first     <= cmd.first;
      s1_lastv     <= cmd.lastv;
      result_valid <= 1'b0;
      // A kept coface waits in the hold until the next kept one or the flush, so that the final one can carry last.
      if (s1_issue && s1_lastv && m != thr) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          result_valid <= 1'b1;
        end
      end
      if (s1_flush) begin
        result_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_issue) begin
      acc <= m;
    end
    if (s1_issue && s1_lastv && m != thr) begin
      pend_index <= s1_index;
      pend_birth <= m;
      if (pend_valid) begin
        result.coface_index <= pend_index;
        result.coface_birth <= pend_birth;
        result.coface_dim   <= dim_q + 2'd1;
        result.found        <= 1'b1;
        result.last         <= 1'b0;
      end
    end
    if (s1_flush) begin
      result.last <= 1'b1;
      if (pend_valid) begin
        result.coface_index <= pend_index;
        result.coface_birth <= pend_birth;
        result.coface_dim   <= dim_q + 2'd1;
        result.found        <= 1'b1;
      end else begin
        result.coface_index <= '0;
        result.coface_birth <= '0;
        result.coface_dim   <= 2'd0;
        result.found        <= 1'b0;
      end
    end
  end

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    s1_flush |=> (result_valid && result.last))
    else $error("query ended without a final result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |->
      (result.last && result.coface_index == '0 && result.coface_dim == 2'd0))
    else $error("empty result malformed");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for cubical_coface_enumerator: drives voxel writes, threshold
// writes and coface queries, predicts every coface burst and checks each result as it appears.
// Depends on cce_pkg and the cubical_coface_enumerator RTL.
`timescale 1ns / 1ps

module tb_top
  import cce_pkg::*;
();

  localparam logic [1:0] DIM_VERTEX   = 2'd0;
  localparam logic [1:0] DIM_EDGE     = 2'd1;
  localparam logic [1:0] DIM_SQUARE   = 2'd2;
  localparam logic [1:0] DIM_INVALID  = 2'd3;
  localparam logic [1:0] TYPE_INVALID = 2'd3;
  localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;

  // Predicts the coface bursts from its own copy of the voxel grid and the threshold.
  class coface_scoreboard;
    logic signed [31:0] voxel_copy [0:32767];
    logic signed [31:0] threshold;
    cce_res_t pending_cofaces [$];
    int error_count;

    function new();
      threshold = MAX_Q;
      error_count = 0;
    endfunction

    function int outstanding();
      return pending_cofaces.size();
    endfunction

    // Neighbours beyond the grid read as the threshold.
    function logic signed [31:0] voxel_at(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0 || x > 31 || y > 31 || z > 31) begin
        return threshold;
      end
      return voxel_copy[{x[4:0], y[4:0], z[4:0]}];
    endfunction

    function void note_request(cce_req_t r);
      int org[3];
      int pos[3];
      int o[3];
      int sp[2];
      bit [2:0] spanned;
      int nsp, e, dir, m, ct, n, i;
      bit valid_cube;
      logic signed [31:0] b, v;
      cce_res_t hits[6];
      cce_res_t res;
      if (r.kind == KIND_WRITE) begin
        voxel_copy[{r.cube_x, r.cube_y, r.cube_z}] = r.voxel_value;
        return;
      end
      org[0] = r.cube_x;
      org[1] = r.cube_y;
      org[2] = r.cube_z;
      nsp = 0;
      valid_cube = 1'b1;
      spanned = '0;
      if (r.cube_dim == DIM_EDGE && r.cube_type != TYPE_INVALID) begin
        sp[0] = r.cube_type;
        nsp = 1;
      end else if (r.cube_dim == DIM_SQUARE && r.cube_type != TYPE_INVALID) begin
        // A square of type t is normal to axis 2-t and spans the other two.
        for (e = 2; e >= 0; e--) begin
          if (e != 2 - int'(r.cube_type)) begin
            sp[nsp] = e;
            nsp++;
          end
        end
      end else if (r.cube_dim != DIM_VERTEX) begin
        valid_cube = 1'b0;
      end
      for (i = 0; i < nsp; i++) spanned[sp[i]] = 1'b1;
      n = 0;
      if (valid_cube) begin
        // Cofaces grow along each free axis, z first, the plus side before the minus side.
        for (e = 2; e >= 0; e--) begin
          if (!spanned[e]) begin
            for (dir = 1; dir >= -1; dir -= 2) begin
              b = r.birth_time;
              for (m = 0; m < (1 << nsp); m++) begin
                pos = org;
                pos[e] += dir;
                for (i = 0; i < nsp; i++) pos[sp[i]] += (m >> i) & 1;
                v = voxel_at(pos[0], pos[1], pos[2]);
                if (v > b) b = v;
              end
              if (b != threshold) begin
                o = org;
                if (dir < 0) o[e] -= 1;
                case (nsp)
                  0: ct = e;
                  1: ct = sp[0] + e - 1;
                  default: ct = 0;
                endcase
                res.coface_index = {2'(ct), 9'(o[2]), 9'(o[1]), 9'(o[0])};
                res.coface_birth = b;
                res.coface_dim = r.cube_dim + 2'd1;
                res.found = 1'b1;
                res.last = 1'b0;
                hits[n] = res;
                n++;
              end
            end
          end
        end
      end
      if (n == 0) begin
        res = '0;
        res.last = 1'b1;
        pending_cofaces.push_back(res);
      end
      for (i = 0; i < n; i++) begin
        res = hits[i];
        res.last = (i == n - 1);
        pending_cofaces.push_back(res);
      end
    endfunction

    function void check_result(cce_res_t got);
      cce_res_t want;
      if (pending_cofaces.size() == 0) begin
        $error("result with no request outstanding: index %0h", got.coface_index);
        error_count++;
        return;
      end
      want = pending_cofaces.pop_front();
      if (got.coface_index !== want.coface_index) begin
        $error("coface_index: expected %0h, got %0h", want.coface_index, got.coface_index);
        error_count++;
      end
      if (got.coface_birth !== want.coface_birth) begin
        $error("coface_birth: expected %0h, got %0h", want.coface_birth, got.coface_birth);
        error_count++;
      end
      if (got.coface_dim !== want.coface_dim) begin
        $error("coface_dim: expected %0d, got %0d", want.coface_dim, got.coface_dim);
        error_count++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, got.found);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        error_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cce_req_t    req = '0;
  logic        busy;
  logic        result_valid;
  cce_res_t    result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  coface_scoreboard board;
  bit written [0:32767];
  int sent = 0;
  int run_left = 0;

  cubical_coface_enumerator uut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst == 1'b0 && result_valid === 1'b1) board.check_result(result);
  end

  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 3);
    if (sel < 8) return $urandom_range(28, 31);
    return $urandom_range(0, 31);
  endfunction

  // Values cluster around the threshold so that skipped cofaces are common.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return board.threshold;
      1: return board.threshold - 1;
      2: return board.threshold + 1;
      3: return MAX_Q;
      4: return MIN_Q;
      5: return {14'd0, 2'($urandom_range(0, 3)), 16'd0};
      6: return {14'h3FFF, 2'($urandom_range(0, 3)), 16'd0};
      default: return $urandom;
    endcase
  endfunction

  function automatic cce_req_t make_write(int x, int y, int z, logic signed [31:0] val);
    cce_req_t r;
    r.kind = KIND_WRITE;
    r.cube_x = 5'(x);
    r.cube_y = 5'(y);
    r.cube_z = 5'(z);
    r.cube_dim = 2'($urandom_range(0, 3));
    r.cube_type = 2'($urandom_range(0, 3));
    r.voxel_value = val;
    r.birth_time = $urandom;
    return r;
  endfunction

  function automatic cce_req_t make_query(int x, int y, int z, logic [1:0] dim,
                                          logic [1:0] ctype, logic signed [31:0] birth);
    cce_req_t r;
    r.kind = KIND_QUERY;
    r.cube_x = 5'(x);
    r.cube_y = 5'(y);
    r.cube_z = 5'(z);
    r.cube_dim = dim;
    r.cube_type = ctype;
    r.voxel_value = $urandom;
    r.birth_time = birth;
    return r;
  endfunction

  task automatic send_request(input cce_req_t r);
    int gap;
    if (run_left > 0) begin
      gap = 0;
      run_left--;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 24) == 0) run_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(r);
    if (r.kind == KIND_WRITE) written[{r.cube_x, r.cube_y, r.cube_z}] = 1'b1;
    sent++;
  endtask

  // Loads every grid voxel next to a cube that has not been written yet, so that a query
  // never reads an undefined entry.
  task automatic fill_around(input int x, input int y, input int z);
    int dx, dy, dz;
    for (dx = -1; dx <= 1; dx++) begin
      for (dy = -1; dy <= 1; dy++) begin
        for (dz = -1; dz <= 1; dz++) begin
          if (x + dx >= 0 && x + dx <= 31 && y + dy >= 0 && y + dy <= 31 &&
              z + dz >= 0 && z + dz <= 31 &&
              !written[{5'(x + dx), 5'(y + dy), 5'(z + dz)}]) begin
            send_request(make_write(x + dx, y + dy, z + dz, pick_value()));
          end
        end
      end
    end
  endtask

  // A voxel write leaves no result behind, so spare idle clocks follow once the scoreboard drains.
  task automatic wait_idle();
    start <= 1'b0;
    while (board.outstanding() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic read_threshold(input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {REG_THRESHOLD, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== want) begin
      $error("skip_threshold: expected %0h, got %0h", want, prdata);
      board.error_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_threshold(input logic [31:0] val);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_THRESHOLD, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    board.threshold = val;
    @(posedge clk);
    read_threshold(val);
  endtask

  task automatic random_phase(input int count);
    int target, x, y, z;
    logic [1:0] dim, ctype;
    target = sent + count;
    while (sent < target) begin
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      if ($urandom_range(0, 9) < 3) begin
        send_request(make_write(x, y, z, pick_value()));
      end else begin
        fill_around(x, y, z);
        dim = ($urandom_range(0, 15) == 0) ? DIM_INVALID : 2'($urandom_range(0, 2));
        ctype = ($urandom_range(0, 15) == 0) ? TYPE_INVALID : 2'($urandom_range(0, 2));
        send_request(make_query(x, y, z, dim, ctype, pick_value()));
      end
    end
  endtask

  initial begin
    int t, phase;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    read_threshold(MAX_Q);

    // At the origin corner the minus-side neighbours lie outside the grid.
    fill_around(0, 0, 0);
    send_request(make_query(0, 0, 0, DIM_VERTEX, TYPE_INVALID, MIN_Q));
    for (t = 0; t < 3; t++) send_request(make_query(0, 0, 0, DIM_EDGE, 2'(t), MIN_Q));
    for (t = 0; t < 3; t++) send_request(make_query(0, 0, 0, DIM_SQUARE, 2'(t), MIN_Q));
    send_request(make_query(0, 0, 0, DIM_EDGE, TYPE_INVALID, 32'sd0));
    send_request(make_query(0, 0, 0, DIM_SQUARE, TYPE_INVALID, 32'sd0));
    send_request(make_query(0, 0, 0, DIM_INVALID, 2'd0, 32'sd0));
    // A birth time at the threshold pushes every coface to the threshold: none is left.
    send_request(make_query(0, 0, 0, DIM_VERTEX, 2'd0, MAX_Q));
    send_request(make_write(31, 31, 31, MAX_Q));
    send_request(make_write(30, 31, 31, MIN_Q));
    fill_around(31, 31, 31);
    send_request(make_query(31, 31, 31, DIM_VERTEX, 2'd0, 32'sh0001_8000));
    // With a zero threshold the cofaces that reach below the origin are emitted and wrap.
    write_threshold(32'd0);
    send_request(make_query(0, 0, 0, DIM_VERTEX, 2'd0, 32'sd1));
    send_request(make_query(31, 31, 31, DIM_SQUARE, 2'd0, 32'sd1));

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1: write_threshold(MIN_Q);
        2: write_threshold($urandom);
        3: write_threshold(32'h0001_0000);
        4: write_threshold(MAX_Q);
        default: ;
      endcase
      random_phase(95);
    end

    wait_idle();
    if (board.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ cubical_coface_enumerator.f @@
sv/cce_pkg.sv
sv/cce_ctrl.sv
sv/cce_datapath.sv
sv/cubical_coface_enumerator.sv
tb/tb_top.sv
